>>> design/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define ASSERT_SYNC(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

>>> design/dsdw_pkg.sv
// constants, types and segment table of the decimal segment display writer
// no dependencies
`default_nettype none

package dsdw_pkg;

  localparam int DIGIT_COUNT_DEF = 8;
  localparam int UNIT_COUNT = 4;
  localparam int SHOWN_DIGITS = 6;
  localparam logic [2:0] DP_RESET = 3'd3;
  localparam logic [7:0] DP_BIT = 8'h80;
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int DIV10_SHIFT = 35;

  typedef struct packed {
    logic [1:0] unit;
    logic [31:0] rest;
    logic [SHOWN_DIGITS-1:0][3:0] digits;
  } dsdw_item_t;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0: code = 8'b0111_1110;
      4'd1: code = 8'b0011_0000;
      4'd2: code = 8'b0110_1101;
      4'd3: code = 8'b0111_1001;
      4'd4: code = 8'b0011_0011;
      4'd5: code = 8'b0101_1011;
      4'd6: code = 8'b0101_1111;
      4'd7: code = 8'b0111_0000;
      4'd8: code = 8'b0111_1111;
      4'd9: code = 8'b0111_0011;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

>>> design/dsdw_ifs.sv
// valid/ready channel interfaces: input items, output frames, configuration
// no dependencies
`default_nettype none

interface dsdw_in_if;
  logic valid;
  logic ready;
  logic [1:0] unit;
  logic [31:0] number;
  modport source (output valid, output unit, output number, input ready);
  modport sink (input valid, input unit, input number, output ready);
endinterface

interface dsdw_out_if;
  logic valid;
  logic ready;
  logic [1:0] unit_out;
  logic [3:0] register_address;
  logic [7:0] register_data;
  logic last;
  modport source (output valid, output unit_out, output register_address,
                  output register_data, output last, input ready);
  modport sink (input valid, input unit_out, input register_address,
                input register_data, input last, output ready);
endinterface

interface dsdw_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] dp_position;
  modport source (output valid, output dp_position, input ready);
  modport sink (input valid, input dp_position, output ready);
endinterface

`default_nettype wire

>>> design/dsdw_digit_stage.sv
// one pipeline stage that peels off one decimal digit by multiply-by-reciprocal
// depends on dsdw_pkg
`default_nettype none

module dsdw_digit_stage #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid_up,
  output logic                ready_up,
  input  dsdw_pkg::dsdw_item_t item_up,
  output logic                valid_dn,
  input  logic                ready_dn,
  output dsdw_pkg::dsdw_item_t item_dn
);
  import dsdw_pkg::*;

  logic [63:0] prod;
  logic [31:0] quot;
  logic [31:0] times_ten;
  dsdw_item_t  item_next;

  assign prod = 64'(item_up.rest) * 64'(DIV10_MAGIC);
  assign quot = 32'(prod[63:DIV10_SHIFT]);
  assign times_ten = {quot[28:0], 3'b000} + {quot[30:0], 1'b0};

  always_comb begin
    item_next = item_up;
    item_next.rest = quot;
    item_next.digits[IDX] = 4'(item_up.rest - times_ten);
  end

  assign ready_up = !valid_dn || ready_dn;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_dn <= 1'b0;
    end else if (ready_up) begin
      valid_dn <= valid_up;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_up) begin
      item_dn <= item_next;
    end
  end

endmodule

`default_nettype wire

>>> design/dsdw_frame_seq.sv
// frame sequencer: turns one converted item into the blanking and digit frames
// depends on dsdw_pkg and dsdw_out_if
`default_nettype none

module dsdw_frame_seq #(
  parameter int DIGIT_COUNT = dsdw_pkg::DIGIT_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid_up,
  output logic                 ready_up,
  input  dsdw_pkg::dsdw_item_t item_up,
  input  logic [2:0]           dp_position,
  dsdw_out_if.source           frames
);
  import dsdw_pkg::*;

  localparam int CW = (2 * DIGIT_COUNT > 1) ? $clog2(2 * DIGIT_COUNT) : 1;
  localparam logic [CW-1:0] LAST_CNT = CW'(2 * DIGIT_COUNT - 1);
  localparam logic [CW-1:0] HALF_CNT = CW'(DIGIT_COUNT);
  localparam int SHOWN = (DIGIT_COUNT < SHOWN_DIGITS) ? DIGIT_COUNT : SHOWN_DIGITS;

  logic                         busy;
  logic [CW-1:0]                cnt;
  logic [1:0]                   unit;
  logic [SHOWN_DIGITS-1:0][3:0] digits;

  logic       out_load;
  logic       phase;
  logic [3:0] didx;
  logic [3:0] sel_digit;
  logic [7:0] data_next;

  assign out_load = busy && (!frames.valid || frames.ready);
  assign ready_up = !busy || (out_load && cnt == LAST_CNT);

  assign phase = (cnt >= HALF_CNT);
  assign didx = phase ? 4'(cnt - HALF_CNT) : 4'(cnt);

  always_comb begin
    sel_digit = 4'd0;
    for (int i = 0; i < SHOWN; i++) begin
      if (didx == 4'(i)) begin
        sel_digit = digits[i];
      end
    end
    data_next = 8'h00;
    if (phase && didx < 4'(SHOWN)) begin
      data_next = seg_code(sel_digit);
      if ({1'b0, dp_position} == didx) begin
        data_next = data_next | DP_BIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
      frames.valid <= 1'b0;
    end else begin
      if (out_load) begin
        frames.valid <= 1'b1;
      end else if (frames.ready) begin
        frames.valid <= 1'b0;
      end
      if (valid_up && ready_up) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (out_load) begin
        cnt <= cnt + CW'(1);
        if (cnt == LAST_CNT) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (valid_up && ready_up) begin
      unit <= item_up.unit;
      digits <= item_up.digits;
    end
    if (out_load) begin
      frames.unit_out <= unit;
      frames.register_address <= didx + 4'd1;
      frames.register_data <= data_next;
      frames.last <= (cnt == LAST_CNT);
    end
  end

endmodule

`default_nettype wire

>>> design/decimal_segment_display_writer_top.sv
// decimal segment display writer: digit pipeline followed by the frame sequencer
// depends on dsdw_pkg, dsdw_ifs, dsdw_digit_stage, dsdw_frame_seq
//
// channels: items carries (unit, number); frames carries one register write per
// transaction (unit_out, register_address, register_data, last); cfg writes the
// decimal point position, accepted in every cycle.
// an item for a unit at or above the unit count is taken and gives no frames.
// every other item gives 2*DIGIT_COUNT frames: registers 1..DIGIT_COUNT blanked,
// then written low digit first, the last frame marked.
// the first frame of an item leaves the frame output register once the item has
// passed every digit stage and the sequencer is free.
// the single frame output register sets the pace: the sequencer takes a new item
// only with the last frame of the one before; up to min(DIGIT_COUNT,6) items wait
// in the digit pipeline, one digit extraction (32x32 reciprocal multiply) per stage.
// reset empties the pipeline and output register and sets the point to digit 3.
// when the receiver stalls, the frame holds and the pipeline fills, then
// items.ready drops; nothing is lost or repeated.
`default_nettype none

module decimal_segment_display_writer_top #(
  parameter int DIGIT_COUNT = dsdw_pkg::DIGIT_COUNT_DEF
) (
  input logic        clk,
  input logic        rst,
  dsdw_in_if.sink    items,
  dsdw_out_if.source frames,
  dsdw_cfg_if.sink   cfg
);
  import dsdw_pkg::*;

  localparam int SHOWN = (DIGIT_COUNT < SHOWN_DIGITS) ? DIGIT_COUNT : SHOWN_DIGITS;

  logic [2:0] dp_position;
  logic       stage_valid [SHOWN+1];
  logic       stage_ready [SHOWN+1];
  dsdw_item_t stage_item  [SHOWN+1];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dp_position <= DP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      dp_position <= cfg.dp_position;
    end
  end

  assign stage_valid[0] = items.valid && (5'(items.unit) < 5'(UNIT_COUNT));
  assign items.ready = stage_ready[0];

  assign stage_item[0] = '{unit: items.unit, rest: items.number, digits: '0};

  for (genvar g = 0; g < SHOWN; g++) begin : g_digit
    dsdw_digit_stage #(
      .IDX (g)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .valid_up (stage_valid[g]),
      .ready_up (stage_ready[g]),
      .item_up  (stage_item[g]),
      .valid_dn (stage_valid[g+1]),
      .ready_dn (stage_ready[g+1]),
      .item_dn  (stage_item[g+1])
    );
  end

  dsdw_frame_seq #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .valid_up    (stage_valid[SHOWN]),
    .ready_up    (stage_ready[SHOWN]),
    .item_up     (stage_item[SHOWN]),
    .dp_position (dp_position),
    .frames      (frames)
  );

endmodule

`default_nettype wire

>>> design/dsdw_checker.sv
// port-level checker for the decimal segment display writer, bound to the top
// depends on assert_macros.svh and decimal_segment_display_writer_top
`default_nettype none
`include "assert_macros.svh"

module dsdw_checker #(
  parameter int DIGIT_COUNT = dsdw_pkg::DIGIT_COUNT_DEF
) (
  input logic       clk,
  input logic       rst,
  input logic       frames_valid,
  input logic       frames_ready,
  input logic [3:0] frames_address,
  input logic [7:0] frames_data,
  input logic       frames_last,
  input logic       cfg_ready
);

  `ASSERT_SYNC(a_frame_held, clk, rst, frames_valid && !frames_ready |=> frames_valid && $stable(frames_data) && $stable(frames_address))
  `ASSERT_SYNC(a_address_range, clk, rst, frames_valid |-> frames_address != 4'd0 && frames_address <= 4'(DIGIT_COUNT))
  `ASSERT_SYNC(a_last_on_top_register, clk, rst, frames_valid && frames_last |-> frames_address == 4'(DIGIT_COUNT))
  `ASSERT_SYNC(a_high_digits_blank, clk, rst, frames_valid && frames_address > 4'd6 |-> frames_data == 8'h00)
  `ASSERT_ALWAYS(a_cfg_always_ready, clk, cfg_ready)

endmodule

bind decimal_segment_display_writer_top dsdw_checker #(
  .DIGIT_COUNT (DIGIT_COUNT)
) u_dsdw_checker (
  .clk            (clk),
  .rst            (rst),
  .frames_valid   (frames.valid),
  .frames_ready   (frames.ready),
  .frames_address (frames.register_address),
  .frames_data    (frames.register_data),
  .frames_last    (frames.last),
  .cfg_ready      (cfg.ready)
);

`default_nettype wire

>>> tb/decimal_segment_display_writer_top_tb.sv
// testbench for decimal_segment_display_writer_top: directed and random items,
// frames checked against a predictor with its own point position copy
// depends on dsdw_pkg, dsdw_ifs and the design top level
`default_nettype none

module decimal_segment_display_writer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIGITS = 8;
  localparam int GAP_PCT = 6;
  localparam int TAIL_CYCLES = 3 * DIGITS;
  localparam logic [7:0] SEG_TABLE [10] = '{
    8'h7E, 8'h30, 8'h6D, 8'h79, 8'h33, 8'h5B, 8'h5F, 8'h70, 8'h7F, 8'h73
  };

  typedef struct packed {
    logic [1:0] unit;
    logic [3:0] addr;
    logic [7:0] data;
    logic       last;
  } frame_t;

  logic clk;
  logic rst;

  dsdw_in_if  items_if ();
  dsdw_out_if frames_if ();
  dsdw_cfg_if cfg_if ();

  decimal_segment_display_writer_top #(.DIGIT_COUNT(DIGITS)) dut (
    .clk   (clk),
    .rst   (rst),
    .items (items_if.sink),
    .frames(frames_if.source),
    .cfg   (cfg_if.sink)
  );

  frame_t      frame_q [$];
  logic [2:0]  dp_model;
  bit          gaps_on;
  bit          stall_on;
  int unsigned item_count;
  int unsigned frame_count;
  int unsigned mismatch_count;
  int unsigned unexpected_count;
  int unsigned dp_seen;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("decimal_segment_display_writer_top verification failed");
    $finish;
  end

  // expected frames for one item: blank pass, then digits low first
  task automatic predict_frames(input logic [1:0] unit, input logic [31:0] number);
    logic [31:0] rest;
    logic [7:0]  code;
    frame_t      f;
    rest = number;
    for (int d = 0; d < DIGITS; d++) begin
      f = '{unit: unit, addr: 4'(d + 1), data: 8'h00, last: 1'b0};
      frame_q.push_back(f);
    end
    for (int d = 0; d < DIGITS; d++) begin
      if (d >= dsdw_pkg::SHOWN_DIGITS) begin
        code = 8'h00;
      end else begin
        code = SEG_TABLE[rest % 10];
        if (d == int'(dp_model)) code = code | dsdw_pkg::DP_BIT;
      end
      rest = rest / 10;
      f = '{unit: unit, addr: 4'(d + 1), data: code, last: (d == DIGITS - 1)};
      frame_q.push_back(f);
    end
  endtask

  task automatic send_item(input logic [1:0] unit, input logic [31:0] number);
    while (gaps_on && $urandom_range(99) < GAP_PCT) begin
      items_if.valid <= 1'b0;
      @(posedge clk);
    end
    items_if.valid  <= 1'b1;
    items_if.unit   <= unit;
    items_if.number <= number;
    do @(posedge clk); while (!items_if.ready);
    predict_frames(unit, number);
    item_count++;
  endtask

  task automatic wait_drained();
    items_if.valid <= 1'b0;
    while (frame_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_dp(input logic [2:0] pos);
    cfg_if.valid       <= 1'b1;
    cfg_if.dp_position <= pos;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    dp_model = pos;
    dp_seen  = dp_seen | (1 << pos);
  endtask

  function automatic logic [31:0] rand_number();
    logic [31:0] p;
    p = 1;
    case ($urandom_range(5))
      0, 1: return $urandom;
      2: return $urandom_range(999_999);
      3: begin
        repeat ($urandom_range(9)) p = p * 10;
        return p - $urandom_range(1);
      end
      4: return $urandom_range(99);
      default: return 32'hFFFF_FFFF - $urandom_range(1000);
    endcase
  endfunction

  // frame checker and receiver stalls
  always @(posedge clk) begin
    frame_t exp_f;
    frame_t got;
    if (!rst && frames_if.valid && frames_if.ready) begin
      got = '{unit: frames_if.unit_out, addr: frames_if.register_address,
              data: frames_if.register_data, last: frames_if.last};
      if (frame_q.size() == 0) begin
        unexpected_count++;
        if (mismatch_count + unexpected_count <= 10)
          $display("unexpected frame unit %0d addr %0d data %h last %0b",
                   got.unit, got.addr, got.data, got.last);
      end else begin
        exp_f = frame_q.pop_front();
        frame_count++;
        if (got !== exp_f) begin
          mismatch_count++;
          if (mismatch_count + unexpected_count <= 10)
            $display("frame mismatch: expected unit %0d addr %0d data %h last %0b, got unit %0d addr %0d data %h last %0b",
                     exp_f.unit, exp_f.addr, exp_f.data, exp_f.last,
                     got.unit, got.addr, got.data, got.last);
        end
      end
    end
    frames_if.ready <= !(stall_on && $urandom_range(99) < GAP_PCT);
  end

  task automatic test_reset_point();
    send_item(2'd0, 32'd0);
    send_item(2'd3, 32'hFFFF_FFFF);
    send_item(2'd1, 32'd123_456);
    send_item(2'd2, 32'd987_654_321);
    send_item(2'd0, 32'd1_000_000);
    wait_drained();
  endtask

  // positions 6 and 7 fall on blank digits, no point shown
  task automatic test_point_positions();
    for (int p = 0; p < 8; p++) begin
      write_dp(3'(p));
      send_item(2'(p), 32'd765_432 + p);
      wait_drained();
    end
  endtask

  task automatic test_units();
    write_dp(3'd0);
    send_item(2'd0, 32'h8000_0000);
    send_item(2'd1, 32'd999_999);
    send_item(2'd2, 32'd9);
    send_item(2'd3, 32'd10);
    wait_drained();
  endtask

  task automatic test_random_items();
    logic [2:0] phase_dp [8];
    phase_dp = '{3'd7, 3'd0, 3'd5, 3'd6, 3'd1, 3'd3, 3'd2, 3'd4};
    for (int ph = 0; ph < 8; ph++) begin
      gaps_on  = !(ph == 3 || ph == 4);
      stall_on = gaps_on;
      write_dp(phase_dp[ph]);
      for (int i = 0; i < 25; i++) begin
        send_item(2'($urandom_range(3)), rand_number());
        if (ph == 5 && i == 12) wait_drained();
      end
      wait_drained();
    end
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    dp_model         = dsdw_pkg::DP_RESET;
    gaps_on          = 1'b1;
    stall_on         = 1'b1;
    item_count       = 0;
    frame_count      = 0;
    mismatch_count   = 0;
    unexpected_count = 0;
    dp_seen          = 1 << dsdw_pkg::DP_RESET;
    rst                <= 1'b1;
    items_if.valid     <= 1'b0;
    items_if.unit      <= '0;
    items_if.number    <= '0;
    cfg_if.valid       <= 1'b0;
    cfg_if.dp_position <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_point();
    test_point_positions();
    test_units();
    test_random_items();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d items sent, %0d frames checked, point positions seen mask %b",
             item_count, frame_count, dp_seen[7:0]);
    if (mismatch_count == 0 && unexpected_count == 0 && frame_q.size() == 0) begin
      $display("decimal_segment_display_writer_top verification clean");
    end else begin
      $display("%0d mismatches, %0d unexpected frames", mismatch_count, unexpected_count);
      $display("decimal_segment_display_writer_top verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
+incdir+design
design/dsdw_pkg.sv
design/dsdw_ifs.sv
design/dsdw_digit_stage.sv
design/dsdw_frame_seq.sv
design/decimal_segment_display_writer_top.sv
design/dsdw_checker.sv
tb/decimal_segment_display_writer_top_tb.sv
